// File: sv/aec_pkg.sv
// Shared types, constants and elaboration-time helpers for the curved envelope block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package aec_pkg;

    localparam int FRAC_BITS  = 15;
    localparam int LVL_BITS   = FRAC_BITS + 1;
    localparam int LEN_BITS   = 24;
    localparam int CURVE_BITS = 16;
    localparam int BND_BITS   = LEN_BITS + 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;
    localparam int EXP_STEPS  = 16;
    localparam int LOG_STEPS  = 16;

    localparam logic [LVL_BITS-1:0] ONE  = LVL_BITS'(1) << FRAC_BITS;
    localparam logic [LVL_BITS-1:0] HALF = LVL_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [7:0]          IP_MAX = 8'd33;

    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN_LEN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_LEN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_CURVE  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_CURVE   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_CURVE = 3'd7;

    typedef enum logic [2:0] {
        SEG_OUTSIDE = 3'd0,
        SEG_ATTACK  = 3'd1,
        SEG_DECAY   = 3'd2,
        SEG_SUSTAIN = 3'd3,
        SEG_RELEASE = 3'd4
    } seg_t;

    // Sideband that rides along the power pipeline.
    typedef struct packed {
        logic [LVL_BITS-1:0] mul;
        logic [LVL_BITS-1:0] add;
        seg_t                seg;
    } side_t;

    // One classified item as it sits in the queue.
    typedef struct packed {
        logic [LEN_BITS-1:0]   offset;
        logic [LEN_BITS-1:0]   len;
        logic [CURVE_BITS-1:0] curve;
        logic                  inv;
        side_t                 side;
    } job_t;

    // One divider stage.
    typedef struct packed {
        logic [LEN_BITS-1:0]   rem;
        logic [FRAC_BITS-1:0]  quo;
        logic [LEN_BITS-1:0]   len;
        logic [CURVE_BITS-1:0] curve;
        logic                  inv;
        side_t                 side;
    } div_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q30 factor 2^-(2^(k-16)) built by repeated floor square roots from one half.
    function automatic logic [63:0] exp_fac(input int k);
        logic [63:0] fac;
        fac = 64'd1 << 29;
        for (int j = EXP_STEPS - 1; j >= k; j--) begin
            fac = isqrt64(fac << 30);
        end
        return fac;
    endfunction

endpackage
`default_nettype wire

// File: sv/aec_queue.sv
// Short item queue between the classifying front end and the compute back end.
// Depends on aec_pkg for job_t and queue sizing.
`default_nettype none
module aec_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire aec_pkg::job_t wr_data,
    input  wire logic          rd_en,
    output aec_pkg::job_t      rd_data,
    output logic               empty,
    output logic [aec_pkg::Q_CNT_W-1:0] count
);
    import aec_pkg::*;

    job_t                mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg,  count_next;

    always_comb begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(wr_en) - Q_CNT_W'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule
`default_nettype wire

// File: sv/aec_front.sv
// Front end: configuration registers, segment boundaries and per-item classification.
// Depends on aec_pkg; feeds aec_queue.
`default_nettype none
module aec_front #(
    parameter int TIME_BITS = 26
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [aec_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [aec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [TIME_BITS-1:0]           in_time,
    input  wire logic [aec_pkg::Q_CNT_W-1:0]    q_count,
    output logic                                q_wr,
    output aec_pkg::job_t                       q_data
);
    import aec_pkg::*;

    localparam int CMP_W = (TIME_BITS > BND_BITS) ? TIME_BITS : BND_BITS;

    logic [LEN_BITS-1:0]   attack_len_reg, decay_len_reg, sustain_len_reg, release_len_reg;
    logic [LVL_BITS-1:0]   sustain_level_reg;
    logic [CURVE_BITS-1:0] attack_curve_reg, decay_curve_reg, release_curve_reg;
    logic [BND_BITS-1:0]   ea_reg, ed_reg, es_reg, er_reg;
    logic [TIME_BITS-1:0]  t_reg;
    logic                  t_valid_reg, t_valid_next;
    logic [CMP_W-1:0]      t_ext;
    logic [CMP_W-1:0]      diff;
    logic [LVL_BITS-1:0]   s_lvl;
    job_t                  job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg    <= '0;
            decay_len_reg     <= '0;
            sustain_len_reg   <= '0;
            release_len_reg   <= '0;
            sustain_level_reg <= ONE;
            attack_curve_reg  <= CURVE_BITS'(4096);
            decay_curve_reg   <= CURVE_BITS'(4096);
            release_curve_reg <= CURVE_BITS'(4096);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ATTACK_LEN:    attack_len_reg    <= cfg_wdata[LEN_BITS-1:0];
                REG_DECAY_LEN:     decay_len_reg     <= cfg_wdata[LEN_BITS-1:0];
                REG_SUSTAIN_LEN:   sustain_len_reg   <= cfg_wdata[LEN_BITS-1:0];
                REG_RELEASE_LEN:   release_len_reg   <= cfg_wdata[LEN_BITS-1:0];
                REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_wdata[LVL_BITS-1:0];
                REG_ATTACK_CURVE:  attack_curve_reg  <= cfg_wdata[CURVE_BITS-1:0];
                REG_DECAY_CURVE:   decay_curve_reg   <= cfg_wdata[CURVE_BITS-1:0];
                REG_RELEASE_CURVE: release_curve_reg <= cfg_wdata[CURVE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Segment end points, refreshed every cycle from the settings.
    always_ff @(posedge aclk) begin
        ea_reg <= BND_BITS'(attack_len_reg);
        ed_reg <= BND_BITS'(attack_len_reg) + BND_BITS'(decay_len_reg);
        es_reg <= BND_BITS'(attack_len_reg) + BND_BITS'(decay_len_reg)
                + BND_BITS'(sustain_len_reg);
        er_reg <= BND_BITS'(attack_len_reg) + BND_BITS'(decay_len_reg)
                + BND_BITS'(sustain_len_reg) + BND_BITS'(release_len_reg);
    end

    // Accept only while the queue can absorb the item in flight plus this one.
    assign in_ready     = (q_count + Q_CNT_W'(t_valid_reg)) < Q_CNT_W'(Q_DEPTH);
    assign t_valid_next = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_valid_reg <= 1'b0;
        end else begin
            t_valid_reg <= t_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (t_valid_next) begin
            t_reg <= in_time;
        end
    end

    assign t_ext = CMP_W'(t_reg);
    assign s_lvl = (sustain_level_reg > ONE) ? ONE : sustain_level_reg;

    always_comb begin
        job      = '0;
        diff     = '0;
        if (t_ext >= CMP_W'(er_reg)) begin
            job.side.seg = SEG_OUTSIDE;
        end else if (t_ext < CMP_W'(ea_reg)) begin
            job.offset   = t_ext[LEN_BITS-1:0];
            job.len      = attack_len_reg;
            job.curve    = attack_curve_reg;
            job.side.mul = ONE;
            job.side.seg = SEG_ATTACK;
        end else if (t_ext < CMP_W'(ed_reg)) begin
            diff         = t_ext - CMP_W'(ea_reg);
            job.offset   = diff[LEN_BITS-1:0];
            job.len      = decay_len_reg;
            job.curve    = decay_curve_reg;
            job.inv      = 1'b1;
            job.side.mul = ONE - s_lvl;
            job.side.add = s_lvl;
            job.side.seg = SEG_DECAY;
        end else if (t_ext < CMP_W'(es_reg)) begin
            job.side.add = s_lvl;
            job.side.seg = SEG_SUSTAIN;
        end else begin
            diff         = t_ext - CMP_W'(es_reg);
            job.offset   = diff[LEN_BITS-1:0];
            job.len      = release_len_reg;
            job.curve    = release_curve_reg;
            job.inv      = 1'b1;
            job.side.mul = s_lvl;
            job.side.seg = SEG_RELEASE;
        end
    end

    assign q_wr   = t_valid_reg;
    assign q_data = job;

endmodule
`default_nettype wire

// File: sv/aec_pow.sv
// Pipelined power unit x^e: log2 by repeated squaring, one multiply, exp2 by constant factors.
// Depends on aec_pkg; all stages advance together on en.
`default_nettype none
module aec_pow (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [aec_pkg::LVL_BITS-1:0]   in_x,
    input  wire logic [aec_pkg::CURVE_BITS-1:0] in_e,
    input  wire aec_pkg::side_t                 in_side,
    output logic                                out_valid,
    output logic [aec_pkg::LVL_BITS-1:0]        out_pw,
    output aec_pkg::side_t                      out_side
);
    import aec_pkg::*;

    typedef struct packed {
        logic [30:0]           m;
        logic [15:0]           frac;
        logic [3:0]            p;
        logic [CURVE_BITS-1:0] e;
        logic                  fz;
        logic                  fo;
        side_t                 side;
    } lg_t;

    typedef struct packed {
        logic [30:0] acc;
        logic [7:0]  ip;
        logic [15:0] fp;
        logic        fz;
        logic        fo;
        side_t       side;
    } ex_t;

    lg_t                 lg_reg  [LOG_STEPS+1];
    logic                lgv_reg [LOG_STEPS+1];
    ex_t                 ex_reg  [EXP_STEPS+1];
    logic                exv_reg [EXP_STEPS+1];
    logic                out_valid_reg;
    logic [LVL_BITS-1:0] out_pw_reg;
    side_t               out_side_reg;

    lg_t         lg0;
    ex_t         ex0;
    logic [19:0] mag;
    logic [35:0] yprod;
    logic [6:0]  sh;
    logic [63:0] num;
    logic [63:0] v;
    logic [LVL_BITS-1:0] pw_next;

    // Entry: special cases, leading one and mantissa normalization.
    always_comb begin
        lg0      = '0;
        lg0.e    = in_e;
        lg0.side = in_side;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (in_x[i]) begin
                lg0.p = 4'(i);
            end
        end
        lg0.m = 31'(32'(in_x) << (6'd30 - 6'(lg0.p)));
        if (in_e == '0) begin
            lg0.fo = 1'b1;
        end else if (in_x == '0) begin
            lg0.fz = 1'b1;
        end else if (in_x >= ONE) begin
            lg0.fo = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lg_reg[0] <= lg0;
        end
    end

    for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_log
        logic [61:0] sq;
        logic [31:0] tq;
        lg_t         nx;
        always_comb begin
            sq = 62'(lg_reg[i-1].m) * 62'(lg_reg[i-1].m);
            tq = sq[61:30];
            nx = lg_reg[i-1];
            if (tq[31]) begin
                nx.m    = tq[31:1];
                nx.frac = {lg_reg[i-1].frac[14:0], 1'b1};
            end else begin
                nx.m    = tq[30:0];
                nx.frac = {lg_reg[i-1].frac[14:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                lg_reg[i] <= nx;
            end
        end
    end

    // Scale the log magnitude by the exponent.
    always_comb begin
        mag      = {4'(FRAC_BITS) - lg_reg[LOG_STEPS].p, 16'h0000}
                 - 20'(lg_reg[LOG_STEPS].frac);
        yprod    = 36'(mag) * 36'(lg_reg[LOG_STEPS].e);
        ex0      = '0;
        ex0.acc  = 31'(1) << 30;
        ex0.ip   = yprod[35:28];
        ex0.fp   = yprod[27:12];
        ex0.fo   = lg_reg[LOG_STEPS].fo;
        ex0.fz   = lg_reg[LOG_STEPS].fz || (!lg_reg[LOG_STEPS].fo && (yprod[35:28] > IP_MAX));
        ex0.side = lg_reg[LOG_STEPS].side;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg[0] <= ex0;
        end
    end

    for (genvar i = 1; i <= EXP_STEPS; i++) begin : g_exp
        localparam logic [29:0] FAC = 30'(exp_fac(EXP_STEPS - i));
        logic [60:0] prod;
        ex_t         nx;
        always_comb begin
            prod = 61'(ex_reg[i-1].acc) * 61'(FAC);
            nx   = ex_reg[i-1];
            if (ex_reg[i-1].fp[EXP_STEPS-i]) begin
                nx.acc = prod[60:30];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                ex_reg[i] <= nx;
            end
        end
    end

    // Apply the integer part of the exponent with round half up, then clamp.
    always_comb begin
        sh  = 7'd30 + 7'(ex_reg[EXP_STEPS].ip);
        num = (64'(ex_reg[EXP_STEPS].acc) << FRAC_BITS) + (64'd1 << (sh - 7'd1));
        v   = num >> sh;
        if (ex_reg[EXP_STEPS].fo) begin
            pw_next = ONE;
        end else if (ex_reg[EXP_STEPS].fz) begin
            pw_next = '0;
        end else if (v > 64'(ONE)) begin
            pw_next = ONE;
        end else begin
            pw_next = v[LVL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_pw_reg   <= pw_next;
            out_side_reg <= ex_reg[EXP_STEPS].side;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= LOG_STEPS; i++) begin
                lgv_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= EXP_STEPS; i++) begin
                exv_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            lgv_reg[0] <= in_valid;
            for (int i = 1; i <= LOG_STEPS; i++) begin
                lgv_reg[i] <= lgv_reg[i-1];
            end
            exv_reg[0] <= lgv_reg[LOG_STEPS];
            for (int i = 1; i <= EXP_STEPS; i++) begin
                exv_reg[i] <= exv_reg[i-1];
            end
            out_valid_reg <= exv_reg[EXP_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pw    = out_pw_reg;
    assign out_side  = out_side_reg;

endmodule
`default_nettype wire

// File: sv/aec_back.sv
// Back end: pipelined ratio divider, power unit, level scaling and output register.
// Depends on aec_pkg and aec_pow; pulls items from aec_queue.
`default_nettype none
module aec_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_empty,
    input  wire aec_pkg::job_t           q_data,
    output logic                         q_rd,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [aec_pkg::LVL_BITS-1:0] out_level,
    output aec_pkg::seg_t                out_seg
);
    import aec_pkg::*;

    div_t                div_reg  [FRAC_BITS+1];
    logic                divv_reg [FRAC_BITS+1];
    logic                en;
    div_t                d0;
    logic [LVL_BITS-1:0] x;
    logic                pw_valid;
    logic [LVL_BITS-1:0] pw;
    side_t               pw_side;
    logic [31:0]         prod;
    logic [LVL_BITS:0]   lvl;
    logic                out_valid_reg;
    logic [LVL_BITS-1:0] out_level_reg, out_level_next;
    seg_t                out_seg_reg;

    // Whole back end advances whenever the output register can take a result.
    assign en   = !out_valid_reg || out_ready;
    assign q_rd = en && !q_empty;

    always_comb begin
        d0       = '0;
        d0.rem   = q_data.offset;
        d0.len   = q_data.len;
        d0.curve = q_data.curve;
        d0.inv   = q_data.inv;
        d0.side  = q_data.side;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0] <= d0;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_div
        logic [LEN_BITS:0] r2;
        logic              ge;
        div_t              nx;
        always_comb begin
            r2 = {div_reg[i-1].rem, 1'b0};
            ge = (r2 >= {1'b0, div_reg[i-1].len});
            nx = div_reg[i-1];
            if (ge) begin
                r2 = r2 - {1'b0, div_reg[i-1].len};
            end
            nx.rem = r2[LEN_BITS-1:0];
            nx.quo = {div_reg[i-1].quo[FRAC_BITS-2:0], ge};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[i] <= nx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= FRAC_BITS; i++) begin
                divv_reg[i] <= 1'b0;
            end
        end else if (en) begin
            divv_reg[0] <= !q_empty;
            for (int i = 1; i <= FRAC_BITS; i++) begin
                divv_reg[i] <= divv_reg[i-1];
            end
        end
    end

    assign x = div_reg[FRAC_BITS].inv ? ONE - LVL_BITS'(div_reg[FRAC_BITS].quo)
                                      : LVL_BITS'(div_reg[FRAC_BITS].quo);

    aec_pow u_pow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (divv_reg[FRAC_BITS]),
        .in_x      (x),
        .in_e      (div_reg[FRAC_BITS].curve),
        .in_side   (div_reg[FRAC_BITS].side),
        .out_valid (pw_valid),
        .out_pw    (pw),
        .out_side  (pw_side)
    );

    always_comb begin
        prod = 32'(pw) * 32'(pw_side.mul) + 32'(HALF);
        lvl  = (LVL_BITS+1)'(prod >> FRAC_BITS) + (LVL_BITS+1)'(pw_side.add);
        out_level_next = (lvl > (LVL_BITS+1)'(ONE)) ? ONE : lvl[LVL_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= pw_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_level_reg <= out_level_next;
            out_seg_reg   <= pw_side.seg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_seg   = out_seg_reg;

endmodule
`default_nettype wire

// File: sv/adsr_envelope_curved.sv
// Top level of the curved ADSR envelope generator: stream ports, config port, wiring.
// Depends on aec_pkg, aec_front, aec_queue, aec_back.
`default_nettype none
// Stateless envelope lookup. Each input item carries a time in ticks since note
// start; each result item carries the envelope level (Q1.15, 32768 = 1.0) and the
// segment the time falls in (0 past the end, 1 attack, 2 decay, 3 sustain,
// 4 release). Attack follows (t/A)^ae, decay (1-(t-A)/D)^de*(1-S)+S, sustain S
// and release (1-u/R)^re*S; the exact end and any later time give level 0.
// Exponents are unsigned Q4.12. Throughput is one item per clock while the output
// is not stalled, set by a fully pipelined datapath: a 15-stage restoring divider
// for the segment ratio, 16 squaring stages for log2, one exponent multiply, 16
// constant-factor stages for exp2, a rounding shift and a scaling multiply. A
// four-item queue decouples the classifying front end from the compute back end,
// so input keeps flowing until the queue is full while a finished result waits on
// m_axis_tready. Write the configuration only while no items are in flight;
// boundary sums are registered from the settings registers and so lag behind a
// write.
module adsr_envelope_curved #(
    parameter int TIME_BITS = 26
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Config: index 0..7 selects attack/decay/sustain/release length,
    // sustain level, attack/decay/release curve.
    input  wire logic                              cfg_we,
    input  wire logic [aec_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [aec_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // s_axis_tdata: [TIME_BITS-1:0] time_ticks, zero padded to whole bytes
    input  wire logic [((TIME_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // m_axis_tdata: [15:0] level
    output logic [aec_pkg::LVL_BITS-1:0]           m_axis_tdata,
    // m_axis_tuser: [2:0] segment
    output logic [2:0]                             m_axis_tuser
);
    import aec_pkg::*;

    logic               q_wr;
    job_t               q_wdata;
    logic               q_rd;
    job_t               q_rdata;
    logic               q_empty;
    logic [Q_CNT_W-1:0] q_count;
    seg_t               seg;

    // Front: hold settings, classify each time against the segment end points.
    aec_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_time   (s_axis_tdata[TIME_BITS-1:0]),
        .q_count   (q_count),
        .q_wr      (q_wr),
        .q_data    (q_wdata)
    );

    // Queue: absorb items while the back end stalls on the output.
    aec_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty),
        .count   (q_count)
    );

    // Back: divide, raise to the curve exponent, scale and hold the result.
    aec_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_rd      (q_rd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_level (m_axis_tdata),
        .out_seg   (seg)
    );

    assign m_axis_tuser = seg;

endmodule
`default_nettype wire

// File: sim/envelope_checker.sv
// Checker for the curved ADSR envelope block: tracks register writes, predicts
// level and segment per time item and compares them with the result stream. Uses aec_pkg.
`default_nettype none
module envelope_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    output int               fails,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import aec_pkg::*;

    localparam longint unsigned UNITY = 64'd1 << 15;
    localparam longint unsigned Q30V  = 64'd1 << 30;

    typedef struct {
        logic [15:0] level;
        seg_t        segment;
    } env_point_t;

    env_point_t levels_due[$];

    longint unsigned len_a, len_d, len_s, len_r, sus_lvl, crv_a, crv_d, crv_r;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, trial;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = res | (64'd1 << b);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    // x^e with x in Q1.15 and e in Q4.12, via log2 / exp2 in fixed point
    function automatic longint unsigned curve_pow(longint unsigned x, longint unsigned e);
        int p;
        longint unsigned m, frac, mag, y, ip, fp, acc, fac, sh;
        if (e == 0) return UNITY;
        if (x == 0) return 0;
        if (x >= UNITY) return UNITY;
        p = 0;
        while ((x >> (p + 1)) != 0) p++;
        m = x << (30 - p);
        frac = 0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 2 * Q30V) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        mag = longint'(15 - p) * 65536 - frac;
        y = (mag * e) >> 12;
        ip = y >> 16;
        fp = y & 64'hFFFF;
        if (ip > 33) return 0;
        acc = Q30V;
        fac = Q30V >> 1;
        for (int k = 15; k >= 0; k--) begin
            fac = floor_sqrt(fac << 30);
            if (fp[k]) acc = (acc * fac) >> 30;
        end
        sh = 30 + ip;
        y = (acc * UNITY + (64'd1 << (sh - 1))) >> sh;
        return (y > UNITY) ? UNITY : y;
    endfunction

    function automatic env_point_t envelope_at(longint unsigned t);
        env_point_t r;
        longint unsigned s, ea, ed, es, er, x, lvl;
        s  = (sus_lvl > UNITY) ? UNITY : sus_lvl;
        ea = len_a;
        ed = ea + len_d;
        es = ed + len_s;
        er = es + len_r;
        if (t >= er) begin
            lvl = 0;
            r.segment = SEG_OUTSIDE;
        end else if (t < ea) begin
            lvl = curve_pow((t << 15) / len_a, crv_a);
            r.segment = SEG_ATTACK;
        end else if (t < ed) begin
            x = UNITY - (((t - ea) << 15) / len_d);
            lvl = ((curve_pow(x, crv_d) * (UNITY - s) + (UNITY >> 1)) >> 15) + s;
            r.segment = SEG_DECAY;
        end else if (t < es) begin
            lvl = s;
            r.segment = SEG_SUSTAIN;
        end else begin
            x = UNITY - (((t - es) << 15) / len_r);
            lvl = (curve_pow(x, crv_r) * s + (UNITY >> 1)) >> 15;
            r.segment = SEG_RELEASE;
        end
        if (lvl > UNITY) lvl = UNITY;
        r.level = lvl[15:0];
        return r;
    endfunction

    assign pending = levels_due.size();

    always @(posedge aclk) begin
        env_point_t want;
        if (!aresetn) begin
            len_a = 0; len_d = 0; len_s = 0; len_r = 0;
            sus_lvl = 32768; crv_a = 4096; crv_d = 4096; crv_r = 4096;
            levels_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ATTACK_LEN:    len_a   = cfg_wdata;
                    REG_DECAY_LEN:     len_d   = cfg_wdata;
                    REG_SUSTAIN_LEN:   len_s   = cfg_wdata;
                    REG_RELEASE_LEN:   len_r   = cfg_wdata;
                    REG_SUSTAIN_LEVEL: sus_lvl = cfg_wdata[15:0];
                    REG_ATTACK_CURVE:  crv_a   = cfg_wdata[15:0];
                    REG_DECAY_CURVE:   crv_d   = cfg_wdata[15:0];
                    REG_RELEASE_CURVE: crv_r   = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                levels_due.push_back(envelope_at(longint'(s_tdata[25:0])));
            if (m_tvalid && m_tready) begin
                if (levels_due.size() == 0) begin
                    $error("unexpected result: level %0d segment %0d", m_tdata, m_tuser);
                    fails++;
                end else begin
                    want = levels_due.pop_front();
                    if (m_tdata !== want.level) begin
                        $error("level: expected %0d, actual %0d", want.level, m_tdata);
                        fails++;
                    end
                    if (m_tuser !== want.segment) begin
                        $error("segment: expected %0d, actual %0d", want.segment, m_tuser);
                        fails++;
                    end
                end
            end
        end
    end

    initial fails = 0;
endmodule
`default_nettype wire

// File: sim/tb_adsr_envelope_curved.sv
// Top of the curved ADSR envelope testbench: clock, reset, register writes and
// time stimulus. Depends on aec_pkg, adsr_envelope_curved and envelope_checker.
`default_nettype none
module tb_adsr_envelope_curved;
    timeunit 1ns;
    timeprecision 1ps;
    import aec_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    // Give the pipeline room to empty before touching registers.
    localparam int DRAIN_CYCLES = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [23:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [25:0] time_ticks
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [15:0] level
    logic [2:0]  m_axis_tuser;        // [2:0] segment

    int fails, pending, cycles;
    bit steady;   // suppress idling on both sides
    longint unsigned env_end;

    adsr_envelope_curved dut (.*);

    envelope_checker level_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser),
        .fails(fails), .pending(pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Stall the result side on about 37 percent of cycles unless held steady.
    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    // Watchdog: end the run if something hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drive one time item and hold it until the block takes it.
    task automatic send_time(input logic [25:0] t);
        while (!steady && $urandom_range(0, 99) < 37) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, t};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [23:0] vals[8]);
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        // Wait for the boundary sums to settle.
        repeat (4) @(posedge aclk);
        env_end = longint'(vals[REG_ATTACK_LEN]) + vals[REG_DECAY_LEN]
                + vals[REG_SUSTAIN_LEN] + vals[REG_RELEASE_LEN];
    endtask

    // Segment edges first, then random times mostly inside the envelope.
    task automatic run_times(input logic [23:0] vals[8], input int n);
        longint unsigned edges[10];
        longint unsigned t;
        edges[0] = 0;
        edges[1] = vals[REG_ATTACK_LEN];
        edges[2] = edges[1] + vals[REG_DECAY_LEN];
        edges[3] = edges[2] + vals[REG_SUSTAIN_LEN];
        edges[4] = env_end;
        edges[5] = (edges[1] > 0) ? edges[1] - 1 : 0;
        edges[6] = (edges[2] > 0) ? edges[2] - 1 : 0;
        edges[7] = (env_end > 0) ? env_end - 1 : 0;
        edges[8] = env_end + 1;
        edges[9] = 64'h3FFFFFF;
        foreach (edges[i]) send_time(edges[i][25:0]);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1: t = {$urandom()} & 64'h3FFFFFF;
                2: t = edges[$urandom_range(0, 8)] + $urandom_range(0, 2) - 1;
                default: t = (env_end > 0) ? ({$urandom()} % (env_end + 2)) : 0;
            endcase
            send_time(t[25:0]);
        end
        drain();
    endtask

    initial begin
        logic [23:0] v[8];
        steady = 1'b0;
        cycles = 0;
        env_end = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: all lengths zero, every time is past the end.
        v = '{0, 0, 0, 0, 32768, 4096, 4096, 4096};
        run_times(v, 10);

        // Linear curves, short segments.
        v = '{8, 6, 5, 7, 16384, 4096, 4096, 4096};
        write_regs(v);
        run_times(v, 30);

        // Zero exponents, sustain level over full scale (taken as full scale).
        v = '{20, 20, 10, 20, 24'hFFFFFF, 0, 0, 0};
        write_regs(v);
        run_times(v, 30);

        // Steepest exponents, zero sustain level; no idling on either side.
        steady = 1'b1;
        v = '{300, 250, 3, 400, 0, 65535, 65535, 65535};
        write_regs(v);
        run_times(v, 60);
        steady = 1'b0;

        // Skipped attack, decay and release.
        v = '{0, 0, 50, 0, 32768, 8192, 2048, 12288};
        write_regs(v);
        run_times(v, 20);

        // Longest segments.
        v = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32768, 1, 1, 1};
        write_regs(v);
        run_times(v, 30);

        // Random settings, mostly short segments.
        for (int ph = 0; ph < 7; ph++) begin
            for (int i = 0; i < 4; i++) begin
                case ($urandom_range(0, 7))
                    0: v[i] = 0;
                    1: v[i] = 24'($urandom());
                    default: v[i] = 24'($urandom_range(1, 400));
                endcase
            end
            v[REG_SUSTAIN_LEVEL] = ($urandom_range(0, 5) == 0) ? 24'($urandom())
                                                              : 24'($urandom_range(0, 32768));
            for (int i = 5; i < 8; i++)
                v[i] = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 65535))
                                                   : 24'($urandom_range(1024, 16384));
            write_regs(v);
            run_times(v, 28);
        end

        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
sv/aec_pkg.sv
sv/aec_queue.sv
sv/aec_front.sv
sv/aec_pow.sv
sv/aec_back.sv
sv/adsr_envelope_curved.sv
sim/envelope_checker.sv
sim/tb_adsr_envelope_curved.sv
